[rtl/tmfq_pkg.sv]
// Shared types and constants for the quaternion-to-TRS matrix pipeline.
// No dependencies; every other file in rtl/ imports this package.
package tmfq_pkg;

   // Number of rotation entries, which is one lane per entry.
   localparam int Lanes     = 9;
   // Width of a signed numerator. Its magnitude is at most 2^32.
   localparam int NumW      = 34;
   // Width of the norm n. Its value is at most 2^32.
   localparam int NormW     = 33;
   // Width of the quotient. One divider stage produces each bit.
   localparam int QuotW     = 32;
   // Width of the remainder. It stays below n.
   localparam int RemW      = 33;
   // Width of one half-scale partial product (33 x 16 bits).
   localparam int PartW     = 49;
   // Width of the rounded dividend, which is below 2^64.
   localparam int DivdW     = 64;
   localparam int DivStages = QuotW;

   // One input item.
   typedef struct packed {
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m03;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m13;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] m23;
   } rsp_type;

   // Quaternion products, registered after the first stage.
   typedef struct packed {
      logic [31:0]        x2;
      logic [31:0]        y2;
      logic [31:0]        z2;
      logic [31:0]        w2;
      logic signed [31:0] xy;
      logic signed [31:0] wz;
      logic signed [31:0] xz;
      logic signed [31:0] wy;
      logic signed [31:0] yz;
      logic signed [31:0] wx;
      logic [2:0][31:0]   scale;
      logic [2:0][31:0]   trans;
   } prod_type;

   // Rotation numerators over the common norm n.
   typedef struct packed {
      logic [Lanes-1:0][NumW-1:0] num;
      logic [NormW-1:0]           norm;
      logic [2:0][31:0]           scale;
      logic [2:0][31:0]           trans;
   } rot_type;

   // Unsigned partial products of |num| * |scale|.
   typedef struct packed {
      logic [Lanes-1:0][PartW-1:0] part_lo;
      logic [Lanes-1:0][PartW-1:0] part_hi;
      logic [Lanes-1:0]            neg;
      logic [NormW-1:0]            norm;
      logic [2:0][31:0]            trans;
   } mul_type;

   // Long division state. The lo field holds the unused low dividend bits,
   // and quotient bits shift in from the right.
   typedef struct packed {
      logic [Lanes-1:0][RemW-1:0]  rem;
      logic [Lanes-1:0][QuotW-1:0] lo;
      logic [Lanes-1:0]            neg;
      logic [NormW-1:0]            norm;
      logic [2:0][31:0]            trans;
   } div_type;

endpackage

[rtl/tmfq_rot.sv]
// Two pipeline stages: the quaternion products, then the norm and the nine
// rotation numerators. Depends on tmfq_pkg.
module tmfq_rot (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tmfq_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tmfq_pkg::rot_type out_data
);
   import tmfq_pkg::*;

   logic     prod_valid_ff;
   prod_type prod_ff;
   prod_type prod_in;
   logic     rot_valid_ff;
   rot_type  rot_ff;
   rot_type  rot_in;
   logic     prod_ready;
   logic     rot_ready;
   logic [NormW-1:0]      norm_sum;
   logic [Lanes-1:0][34:0] num_wide;

   // An empty stage, or a stage whose item moves on, can take a new item.
   assign rot_ready  = !rot_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || rot_ready;
   assign in_ready   = prod_ready;

   // Form the squares and the cross products of the quaternion components.
   // Each operand is widened first, so every product is a full 32-bit value.
   always_comb begin
      prod_in.x2    = 32'(in_data.quat_x) * 32'(in_data.quat_x);
      prod_in.y2    = 32'(in_data.quat_y) * 32'(in_data.quat_y);
      prod_in.z2    = 32'(in_data.quat_z) * 32'(in_data.quat_z);
      prod_in.w2    = 32'(in_data.quat_w) * 32'(in_data.quat_w);
      prod_in.xy    = 32'(in_data.quat_x) * 32'(in_data.quat_y);
      prod_in.wz    = 32'(in_data.quat_w) * 32'(in_data.quat_z);
      prod_in.xz    = 32'(in_data.quat_x) * 32'(in_data.quat_z);
      prod_in.wy    = 32'(in_data.quat_w) * 32'(in_data.quat_y);
      prod_in.yz    = 32'(in_data.quat_y) * 32'(in_data.quat_z);
      prod_in.wx    = 32'(in_data.quat_w) * 32'(in_data.quat_x);
      prod_in.scale = {in_data.scale_z, in_data.scale_y, in_data.scale_x};
      prod_in.trans = {in_data.trans_z, in_data.trans_y, in_data.trans_x};
   end

   // Build the numerators in 35-bit wrapping arithmetic. Every true value fits
   // in 34 signed bits, so truncating afterward is exact.
   always_comb begin
      norm_sum    = NormW'(prod_ff.x2) + NormW'(prod_ff.y2)
                  + NormW'(prod_ff.z2) + NormW'(prod_ff.w2);
      num_wide[0] = 35'(norm_sum) - ((35'(prod_ff.y2) + 35'(prod_ff.z2)) << 1);
      num_wide[1] = (35'(prod_ff.xy) - 35'(prod_ff.wz)) << 1;
      num_wide[2] = (35'(prod_ff.xz) + 35'(prod_ff.wy)) << 1;
      num_wide[3] = (35'(prod_ff.xy) + 35'(prod_ff.wz)) << 1;
      num_wide[4] = 35'(norm_sum) - ((35'(prod_ff.x2) + 35'(prod_ff.z2)) << 1);
      num_wide[5] = (35'(prod_ff.yz) - 35'(prod_ff.wx)) << 1;
      num_wide[6] = (35'(prod_ff.xz) - 35'(prod_ff.wy)) << 1;
      num_wide[7] = (35'(prod_ff.yz) + 35'(prod_ff.wx)) << 1;
      num_wide[8] = 35'(norm_sum) - ((35'(prod_ff.x2) + 35'(prod_ff.y2)) << 1);
      for (int k = 0; k < Lanes; k++) begin
         rot_in.num[k] = NumW'(num_wide[k]);
      end
      rot_in.norm = norm_sum;
      // An all-zero quaternion gives the identity rotation over a norm of one.
      if (norm_sum == '0) begin
         for (int k = 0; k < Lanes; k++) begin
            rot_in.num[k] = (k % 4 == 0) ? NumW'(1) : '0;
         end
         rot_in.norm = NormW'(1);
      end
      rot_in.scale = prod_ff.scale;
      rot_in.trans = prod_ff.trans;
   end

   // Stage registers. Valid bits reset, and the data registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rot_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) prod_valid_ff <= in_valid;
         if (rot_ready)  rot_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) prod_ff <= prod_in;
      if (rot_ready)  rot_ff  <= rot_in;
   end

   assign out_valid = rot_valid_ff;
   assign out_data  = rot_ff;

endmodule

[rtl/tmfq_mul.sv]
// Two pipeline stages: magnitudes and split products of numerator times scale,
// then the rounded dividend that starts each divider lane. Depends on tmfq_pkg.
module tmfq_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tmfq_pkg::rot_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tmfq_pkg::div_type out_data
);
   import tmfq_pkg::*;

   logic    mul_valid_ff;
   mul_type mul_ff;
   mul_type mul_in;
   logic    sum_valid_ff;
   div_type sum_ff;
   div_type sum_in;
   logic    mul_ready;
   logic    sum_ready;
   logic [Lanes-1:0][NumW-2:0] num_mag;
   logic [2:0][31:0]           scale_mag;
   logic [Lanes-1:0][DivdW-1:0] divd;

   assign sum_ready = !sum_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign in_ready  = mul_ready;

   // Take magnitudes, then multiply by each 16-bit half of the scale.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         scale_mag[j] = in_data.scale[j][31] ? 32'(-in_data.scale[j]) : in_data.scale[j];
      end
      for (int k = 0; k < Lanes; k++) begin
         num_mag[k] = in_data.num[k][NumW-1] ? (NumW-1)'(-in_data.num[k])
                                             : (NumW-1)'(in_data.num[k]);
         mul_in.part_lo[k] = PartW'(num_mag[k]) * PartW'(scale_mag[k % 3][15:0]);
         mul_in.part_hi[k] = PartW'(num_mag[k]) * PartW'(scale_mag[k % 3][31:16]);
         mul_in.neg[k]     = in_data.num[k][NumW-1] ^ in_data.scale[k % 3][31];
      end
      mul_in.norm  = in_data.norm;
      mul_in.trans = in_data.trans;
   end

   // Join the halves and add half the norm, which rounds ties away from zero.
   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         divd[k] = DivdW'({mul_ff.part_hi[k], 16'b0}) + DivdW'(mul_ff.part_lo[k])
                 + DivdW'(mul_ff.norm >> 1);
         sum_in.rem[k] = RemW'(divd[k][DivdW-1:QuotW]);
         sum_in.lo[k]  = divd[k][QuotW-1:0];
      end
      sum_in.neg   = mul_ff.neg;
      sum_in.norm  = mul_ff.norm;
      sum_in.trans = mul_ff.trans;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) mul_valid_ff <= in_valid;
         if (sum_ready) sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready) mul_ff <= mul_in;
      if (sum_ready) sum_ff <= sum_in;
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

endmodule

[rtl/tmfq_div.sv]
// Pipelined restoring divider: nine lanes share one norm, and each stage
// produces one quotient bit per lane. Depends on tmfq_pkg.
module tmfq_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tmfq_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tmfq_pkg::div_type out_data
);
   import tmfq_pkg::*;

   logic [DivStages-1:0] stage_valid_ff;
   div_type              stage_ff [DivStages];
   div_type              stage_in [DivStages];
   logic [DivStages:0]   stage_ready;

   assign stage_ready[DivStages] = out_ready;

   for (genvar g = 0; g < DivStages; g++) begin : g_stage
      div_type src;
      logic [RemW:0] trial;
      logic          fits;

      assign src = (g == 0) ? in_data : stage_ff[(g == 0) ? 0 : g - 1];
      assign stage_ready[g] = !stage_valid_ff[g] || stage_ready[g + 1];

      // Shift in the next dividend bit and subtract the norm where it fits.
      always_comb begin
         stage_in[g] = src;
         for (int k = 0; k < Lanes; k++) begin
            trial = {src.rem[k], src.lo[k][QuotW-1]};
            fits  = (trial >= {1'b0, src.norm});
            stage_in[g].rem[k] = fits ? RemW'(trial - {1'b0, src.norm}) : RemW'(trial);
            stage_in[g].lo[k]  = {src.lo[k][QuotW-2:0], fits};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            stage_valid_ff[g] <= (g == 0) ? in_valid : stage_valid_ff[(g == 0) ? 0 : g - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[g]) stage_ff[g] <= stage_in[g];
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = stage_valid_ff[DivStages-1];
   assign out_data  = stage_ff[DivStages-1];

endmodule

[rtl/trs_matrix_from_quaternion.sv]
// Top level of the TRS matrix composer: it chains the product, multiply and
// divider pipelines and ends in the output register. Depends on tmfq_pkg.
//
// Use: each req_ item carries a translation, a raw quaternion and a per-axis
// scale. Each rsp_ item returns the top three rows of Translate * R * Scale:
// the entries R_ij * S_j, rounded half away from zero and saturated to
// Q16.16, and the translation column passed through. An all-zero quaternion
// gives the identity rotation.
// An accepted item passes through two product stages, two multiply stages,
// 32 divider stages (one quotient bit each) and the output register before
// rsp_valid rises. The block takes one item per cycle while rsp_stall is low.
// Every stage holds its item while the next stage is full and stalled, so
// stalls fill the bubbles first. req_stall rises only when all stages, the
// output register included, hold items and rsp_stall is high. A synchronous
// reset empties the pipeline, and items in flight are dropped.
module trs_matrix_from_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tmfq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmfq_pkg::rsp_type rsp_data
);
   import tmfq_pkg::*;

   logic    rot_valid;
   logic    rot_ready;
   rot_type rot_data;
   logic    mul_valid;
   logic    mul_ready;
   div_type mul_data;
   logic    div_valid;
   logic    div_ready;
   div_type div_data;
   logic    req_ready;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic [Lanes-1:0][31:0] entry;

   tmfq_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   tmfq_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   tmfq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign req_stall = !req_ready;
   assign div_ready = !rsp_valid_ff || !rsp_stall;

   // Apply the sign and clamp the positive overflow. A negative quotient never
   // exceeds 2^31.
   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         if (div_data.neg[k]) begin
            entry[k] = 32'(-div_data.lo[k]);
         end else begin
            entry[k] = div_data.lo[k][QuotW-1] ? 32'h7FFF_FFFF : div_data.lo[k];
         end
      end
      rsp_data_in.m00 = entry[0];
      rsp_data_in.m01 = entry[1];
      rsp_data_in.m02 = entry[2];
      rsp_data_in.m03 = div_data.trans[0];
      rsp_data_in.m10 = entry[3];
      rsp_data_in.m11 = entry[4];
      rsp_data_in.m12 = entry[5];
      rsp_data_in.m13 = div_data.trans[1];
      rsp_data_in.m20 = entry[6];
      rsp_data_in.m21 = entry[7];
      rsp_data_in.m22 = entry[8];
      rsp_data_in.m23 = div_data.trans[2];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Backpressure reaches the input only when the output is full and stalled.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output side was free");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[dv/trs_matrix_checker.sv]
// Checker for the TRS matrix composer: watches both item channels, predicts
// each result matrix from the accepted request and compares field by field.
// Depends on tmfq_pkg.
module trs_matrix_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tmfq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tmfq_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                matrix_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tmfq_pkg::*;

   rsp_type expected_matrices[$];

   // One scaled rotation entry: num * s / n, rounded half away from zero,
   // then saturated to the signed 32-bit range.
   function automatic logic [31:0] scale_entry(longint num, longint s, longint n);
      logic          neg;
      logic [127:0]  prod;
      logic [127:0]  q;
      neg = (num < 0) != (s < 0);
      prod = 128'(num < 0 ? -num : num) * 128'(s < 0 ? -s : s);
      q = (prod + 128'(n / 2)) / 128'(n);
      if (q == 0) return 32'd0;
      if (!neg) return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q[31:0]);
   endfunction

   // Build the whole expected result item for one request.
   function automatic rsp_type compose_matrix(req_type r);
      longint  x, y, z, w, n;
      longint  num[3][3];
      longint  s[3];
      rsp_type m;
      x = r.quat_x; y = r.quat_y; z = r.quat_z; w = r.quat_w;
      s[0] = r.scale_x; s[1] = r.scale_y; s[2] = r.scale_z;
      n = x*x + y*y + z*z + w*w;
      if (n == 0) begin
         // The zero quaternion stands for the identity rotation.
         foreach (num[i, j]) num[i][j] = (i == j) ? 1 : 0;
         n = 1;
      end else begin
         num[0][0] = n - 2*(y*y + z*z);
         num[0][1] = 2*(x*y - w*z);
         num[0][2] = 2*(x*z + w*y);
         num[1][0] = 2*(x*y + w*z);
         num[1][1] = n - 2*(x*x + z*z);
         num[1][2] = 2*(y*z - w*x);
         num[2][0] = 2*(x*z - w*y);
         num[2][1] = 2*(y*z + w*x);
         num[2][2] = n - 2*(x*x + y*y);
      end
      m.m00 = scale_entry(num[0][0], s[0], n);
      m.m01 = scale_entry(num[0][1], s[1], n);
      m.m02 = scale_entry(num[0][2], s[2], n);
      m.m03 = r.trans_x;
      m.m10 = scale_entry(num[1][0], s[0], n);
      m.m11 = scale_entry(num[1][1], s[1], n);
      m.m12 = scale_entry(num[1][2], s[2], n);
      m.m13 = r.trans_y;
      m.m20 = scale_entry(num[2][0], s[0], n);
      m.m21 = scale_entry(num[2][1], s[1], n);
      m.m22 = scale_entry(num[2][2], s[2], n);
      m.m23 = r.trans_z;
      return m;
   endfunction

   assign pending_count = expected_matrices.size();

   // Predict on each accepted request; compare on each accepted result.
   always @(posedge clock) begin
      rsp_type exp_m;
      logic [11:0][31:0] e, a;
      if (reset) begin
         fail_count <= 0;
         matrix_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_matrices.push_back(compose_matrix(req_data));
         if (rsp_valid && !rsp_stall) begin
            matrix_count <= matrix_count + 1;
            if (expected_matrices.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_m = expected_matrices.pop_front();
               e = exp_m;
               a = rsp_data;
               // Entry 11 is m00 down to entry 0, m23.
               for (int k = 11; k >= 0; k--)
                  if (e[k] !== a[k])
                     $display("%0t: entry m%0d%0d expected %h actual %h", $time,
                              (11 - k) / 4, (11 - k) % 4, e[k], a[k]);
               if (e !== a) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

[dv/testbench.sv]
// Top of the TRS matrix composer testbench: clock, reset, request stimulus
// with bursts and gaps, random result stalls and the verdict.
// Depends on tmfq_pkg, trs_matrix_from_quaternion and trs_matrix_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tmfq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count, matrix_count;
   req_type directed_items[$];

   trs_matrix_from_quaternion DUT (.*);
   trs_matrix_checker checker_inst (.*);

   always #1 clock = ~clock;

   // Random 16-bit component, often at the extremes.
   function automatic logic [15:0] pick_component();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Random Q16.16 value, often at the extremes or near one.
   function automatic logic [31:0] pick_fixed();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0001_0000;
         3: return 32'hFFFF_0000;
         4: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.trans_x = pick_fixed(); r.trans_y = pick_fixed(); r.trans_z = pick_fixed();
      r.quat_x = pick_component(); r.quat_y = pick_component();
      r.quat_z = pick_component(); r.quat_w = pick_component();
      r.scale_x = pick_fixed(); r.scale_y = pick_fixed(); r.scale_z = pick_fixed();
      if ($urandom_range(0, 15) == 0) {r.quat_x, r.quat_y, r.quat_z, r.quat_w} = '0;
      return r;
   endfunction

   function automatic req_type make_item(logic [31:0] t, logic [15:0] qx, logic [15:0] qy,
                                         logic [15:0] qz, logic [15:0] qw, logic [31:0] s);
      req_type r;
      r.trans_x = t; r.trans_y = ~t; r.trans_z = t ^ 32'h5A5A_A5A5;
      r.quat_x = qx; r.quat_y = qy; r.quat_z = qz; r.quat_w = qw;
      r.scale_x = s; r.scale_y = s; r.scale_z = s;
      return r;
   endfunction

   // Send one item, holding it until the block accepts it.
   task automatic send_item(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver stalls in random phases: none, light, heavy.
   always @(posedge clock) begin
      int mode;
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial begin
      int burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: identity, zero quaternion, extremes, negative unit rotation.
      directed_items.push_back(make_item(32'h0, 16'h0, 16'h0, 16'h0, 16'h1, 32'h0001_0000));
      directed_items.push_back(make_item(32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0,
                                         32'h8000_0000));
      directed_items.push_back(make_item(32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h0,
                                         32'h7FFF_FFFF));
      directed_items.push_back(make_item(32'h1, 16'h1, 16'h0, 16'h0, 16'h0, 32'h8000_0000));
      directed_items.push_back(make_item(32'h2, 16'h0, 16'h1, 16'h0, 16'h0, 32'h8000_0000));
      directed_items.push_back(make_item(32'h3, 16'h0, 16'h0, 16'h1, 16'h0, 32'h8000_0000));
      directed_items.push_back(make_item(32'h4, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                         32'h7FFF_FFFF));
      directed_items.push_back(make_item(32'h5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                         32'h8000_0000));
      directed_items.push_back(make_item(32'h6, 16'h8000, 16'h0, 16'h0, 16'h7FFF,
                                         32'hFFFF_FFFF));
      directed_items.push_back(make_item(32'h7, 16'h1, 16'h2, 16'h3, 16'h4, 32'h0000_0001));
      directed_items.push_back(make_item(32'h8, 16'h1, 16'h1, 16'h0, 16'h0, 32'h0000_0003));
      directed_items.push_back(make_item(32'h9, 16'hFFFF, 16'h1, 16'hFFFF, 16'h1,
                                         32'hFFFF_0000));
      foreach (directed_items[i]) send_item(directed_items[i]);
      // Random items in bursts with gaps in between.
      for (int sent = 0; sent < 400; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < 400; k++, sent++) send_item(random_item());
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(posedge clock);
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Checked %0d result matrices from directed and random items,", matrix_count);
      $display("covering zero, unit and extreme quaternions, scales and stalls.");
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #200000;
      $display("FAILURE");
      $finish;
   end
endmodule

[filelist.f]
rtl/tmfq_pkg.sv
rtl/tmfq_rot.sv
rtl/tmfq_mul.sv
rtl/tmfq_div.sv
rtl/trs_matrix_from_quaternion.sv
dv/trs_matrix_checker.sv
dv/testbench.sv
